// File: rtl/swld_pkg.sv
// Package with shared constants, types and helpers of the sync word deframer.
package swld_pkg;

  localparam int unsigned SYNC_BYTES      = 4;
  localparam int unsigned LENGTH_BITS     = 16;
  localparam int unsigned PROCESS_BIT_POS = 31;
  localparam int unsigned PAYLOAD_BIT_POS = 30;

  localparam int unsigned ADDR_W = 3;

  localparam logic [31:0] SYNC_WORD_RST   = 32'h0000_0000;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

  localparam logic [31:0] LENGTH_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic {
    REG_SYNC_WORD   = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_HEADER  = 1'b1
  } out_kind_e;

  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] frame_length;
    logic        process_flag;
    logic        payload_flag;
    logic        last;
  } result_t;

  function automatic logic [7:0] sync_byte(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = word[31:24];
      2'd1:    b = word[23:16];
      2'd2:    b = word[15:8];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

// File: rtl/sync_word_length_deframer.sv
// Top level of the sync word and length prefix byte stream deframer.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   input    | in_valid_i / in_ready_o | stream_byte_i
//   output   | out_valid_o / out_ready_i | out_kind_o, out_byte_o, frame_length_o,
//            |                        | process_flag_o, payload_flag_o, last_o
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One item is accepted per cycle while the skid register is empty; its result is registered.
// The frame state is updated by a single pass of compare and count logic on acceptance.
// A skid register holds one extra result, so input stalls only when it is full.
// Reset clears the frame state and both result valid flags, and loads the configuration reset values.
module sync_word_length_deframer
  import swld_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          stream_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_kind_o,
  output logic [7:0]          out_byte_o,
  output logic [15:0]         frame_length_o,
  output logic                process_flag_o,
  output logic                payload_flag_o,
  output logic                last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0] sync_word_q;
  logic [15:0] max_payload_q;

  phase_e      phase_q, phase_d;
  logic [1:0]  sync_index_q, sync_index_d;
  logic [23:0] header_shift_q, header_shift_d;
  logic [1:0]  header_count_q, header_count_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [15:0] deliver_left_q, deliver_left_d;
  logic [1:0]  frame_flags_q, frame_flags_d;

  result_t     res;
  logic        res_vld;
  result_t     out_q, skid_q;
  logic        out_vld_q, skid_vld_q;

  logic        accept;
  logic        out_fire;
  logic        cfg_wr;
  logic [31:0] hdr_word;
  logic [15:0] hdr_len;
  logic [2:0]  sync_next;
  logic [15:0] bytes_dec;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (reg_idx_e'(paddr[2]) == REG_MAX_PAYLOAD) ? {16'h0000, max_payload_q}
                                                             : sync_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q   <= SYNC_WORD_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_SYNC_WORD:   sync_word_q   <= pwdata;
        REG_MAX_PAYLOAD: max_payload_q <= pwdata[15:0];
        default:         sync_word_q   <= sync_word_q;
      endcase
    end
  end

  assign in_ready_o = !skid_vld_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  assign hdr_word  = {header_shift_q, stream_byte_i};
  assign hdr_len   = 16'(hdr_word & LENGTH_MASK);
  assign sync_next = {1'b0, sync_index_q} + 3'd1;
  assign bytes_dec = (bytes_left_q != 16'd0) ? bytes_left_q - 16'd1 : bytes_left_q;

  always_comb begin
    phase_d        = phase_q;
    sync_index_d   = sync_index_q;
    header_shift_d = header_shift_q;
    header_count_d = header_count_q;
    bytes_left_d   = bytes_left_q;
    deliver_left_d = deliver_left_q;
    frame_flags_d  = frame_flags_q;
    res_vld        = 1'b0;
    res            = '{kind: KIND_PAYLOAD, data: 8'h00, frame_length: 16'h0000,
                       process_flag: 1'b0, payload_flag: 1'b0, last: 1'b0};
    unique case (phase_q)
      PH_HEADER: begin
        if (header_count_q != 2'd3) begin
          header_shift_d = {header_shift_q[15:0], stream_byte_i};
          header_count_d = header_count_q + 2'd1;
        end else begin
          frame_flags_d      = {hdr_word[PROCESS_BIT_POS], hdr_word[PAYLOAD_BIT_POS]};
          bytes_left_d       = hdr_len;
          deliver_left_d     = (hdr_len < max_payload_q) ? hdr_len : max_payload_q;
          header_shift_d     = 24'h000000;
          header_count_d     = 2'd0;
          phase_d            = (hdr_len == 16'd0) ? PH_HUNT : PH_PAYLOAD;
          sync_index_d       = 2'd0;
          res_vld            = 1'b1;
          res.kind           = KIND_HEADER;
          res.frame_length   = hdr_len;
          res.process_flag   = hdr_word[PROCESS_BIT_POS];
          res.payload_flag   = hdr_word[PAYLOAD_BIT_POS];
        end
      end
      PH_PAYLOAD: begin
        if (deliver_left_q != 16'd0) begin
          res_vld          = 1'b1;
          res.data         = stream_byte_i;
          res.process_flag = frame_flags_q[1];
          res.payload_flag = frame_flags_q[0];
          res.last         = (deliver_left_q == 16'd1);
          deliver_left_d   = deliver_left_q - 16'd1;
        end
        bytes_left_d = bytes_dec;
        if (bytes_dec == 16'd0) begin
          deliver_left_d = 16'd0;
          phase_d        = PH_HUNT;
          sync_index_d   = 2'd0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        if (stream_byte_i == sync_byte(sync_word_q,
                                       (phase_q == PH_HUNT) ? sync_index_q : 2'd0)) begin
          if (phase_q != PH_HUNT || sync_next >= 3'(SYNC_BYTES)) begin
            if (phase_q != PH_HUNT && SYNC_BYTES > 1) begin
              sync_index_d = 2'd1;
            end else begin
              sync_index_d   = 2'd0;
              phase_d        = PH_HEADER;
              header_shift_d = 24'h000000;
              header_count_d = 2'd0;
            end
          end else begin
            sync_index_d = sync_next[1:0];
          end
        end else begin
          sync_index_d = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      sync_index_q   <= 2'd0;
      header_shift_q <= 24'h000000;
      header_count_q <= 2'd0;
      bytes_left_q   <= 16'd0;
      deliver_left_q <= 16'd0;
      frame_flags_q  <= 2'd0;
    end else if (accept) begin
      phase_q        <= phase_d;
      sync_index_q   <= sync_index_d;
      header_shift_q <= header_shift_d;
      header_count_q <= header_count_d;
      bytes_left_q   <= bytes_left_d;
      deliver_left_q <= deliver_left_d;
      frame_flags_q  <= frame_flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_fire) begin
      out_vld_q <= accept && res_vld;
    end else if (accept && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_fire) begin
      out_q <= res;
    end else if (accept && res_vld) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_kind_o     = out_q.kind;
  assign out_byte_o     = out_q.data;
  assign frame_length_o = out_q.frame_length;
  assign process_flag_o = out_q.process_flag;
  assign payload_flag_o = out_q.payload_flag;
  assign last_o         = out_q.last;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == KIND_HEADER) |-> (out_q.data == 8'h00 && !out_q.last))
    else $error("header result carries payload byte or last flag");

  a_deliver_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deliver_left_q <= bytes_left_q)
    else $error("more payload bytes to deliver than left in the frame");

  a_header_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (header_count_q == 2'd0))
    else $error("header byte count left nonzero outside the header phase");

endmodule

// File: test/tb_sync_word_length_deframer.sv
// Self-checking testbench for the sync word and length prefix deframer.
module tb_sync_word_length_deframer;
  import swld_pkg::*;

  localparam int PHASE_ITEMS  = 190;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 500000;

  class frame_tracker;
    logic [31:0] sync_word;
    logic [15:0] max_payload;
    phase_e      phase;
    logic [1:0]  sync_idx;
    logic [23:0] hdr_shift;
    logic [1:0]  hdr_count;
    logic [15:0] bytes_left;
    logic [15:0] deliver_left;
    logic [1:0]  frame_flags;
    result_t     due_results[$];
    int          errors;
    int          headers;
    int          payloads;

    function new();
      sync_word    = SYNC_WORD_RST;
      max_payload  = MAX_PAYLOAD_RST;
      phase        = PH_HUNT;
      sync_idx     = '0;
      hdr_shift    = '0;
      hdr_count    = '0;
      bytes_left   = '0;
      deliver_left = '0;
      frame_flags  = '0;
      errors       = 0;
      headers      = 0;
      payloads     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_SYNC_WORD:   sync_word = value;
        REG_MAX_PAYLOAD: max_payload = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t     r;
      logic [31:0] word;
      r = '0;
      case (phase)
        PH_HEADER: begin
          if (hdr_count != 2'd3) begin
            hdr_shift = {hdr_shift[15:0], b};
            hdr_count++;
          end else begin
            word = {hdr_shift, b};
            r.kind = KIND_HEADER;
            r.frame_length = 16'(word & LENGTH_MASK);
            r.process_flag = word[PROCESS_BIT_POS];
            r.payload_flag = word[PAYLOAD_BIT_POS];
            frame_flags = {r.process_flag, r.payload_flag};
            bytes_left = r.frame_length;
            deliver_left = (r.frame_length < max_payload) ? r.frame_length : max_payload;
            hdr_shift = '0;
            hdr_count = '0;
            sync_idx = '0;
            phase = (r.frame_length == 16'd0) ? PH_HUNT : PH_PAYLOAD;
            due_results.push_back(r);
          end
        end
        PH_PAYLOAD: begin
          if (deliver_left != 16'd0) begin
            r.kind = KIND_PAYLOAD;
            r.data = b;
            r.process_flag = frame_flags[1];
            r.payload_flag = frame_flags[0];
            r.last = (deliver_left == 16'd1);
            deliver_left--;
            due_results.push_back(r);
          end
          if (bytes_left != 16'd0) bytes_left--;
          if (bytes_left == 16'd0) begin
            deliver_left = '0;
            phase = PH_HUNT;
            sync_idx = '0;
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == sync_word[31 - 8 * int'(sync_idx) -: 8]) begin
            if (int'(sync_idx) + 1 >= SYNC_BYTES) begin
              sync_idx = '0;
              phase = PH_HEADER;
              hdr_shift = '0;
              hdr_count = '0;
            end else begin
              sync_idx++;
            end
          end else begin
            sync_idx = '0;
          end
        end
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("kind %0d byte %02h length %0d process %0b payload %0b last %0b",
                       r.kind, r.data, r.frame_length, r.process_flag, r.payload_flag,
                       r.last);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result: %s", show(got));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.frame_length !== want.frame_length || got.process_flag !== want.process_flag ||
          got.payload_flag !== want.payload_flag || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: expected %s", show(want));
          $display("       actual   %s", show(got));
        end
      end else if (got.kind == KIND_HEADER) begin
        headers++;
      end else begin
        payloads++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        stream_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              out_kind_o;
  logic [7:0]        out_byte_o;
  logic [15:0]       frame_length_o;
  logic              process_flag_o;
  logic              payload_flag_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  frame_tracker tracker = new();
  logic [31:0]  cur_sync;
  bit           quiet;
  int           items_sent;
  int           settings_used;
  int           cycle_count;

  sync_word_length_deframer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .frame_length_o (frame_length_o),
    .process_flag_o (process_flag_o),
    .payload_flag_o (payload_flag_o),
    .last_o         (last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int draw_wait();
    return quiet ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == cur_sync[31:24]);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_byte(b);
    items_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[31 - 8 * i -: 8]);
  endtask

  task automatic send_frame(input logic [31:0] header);
    send_word(cur_sync);
    send_word(header);
    repeat (int'(header[15:0])) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken();
    int         k;
    logic [7:0] b;
    k = $urandom_range(1, SYNC_BYTES - 1);
    for (int i = 0; i < k; i++) send_byte(cur_sync[31 - 8 * i -: 8]);
    b = $urandom_range(0, 1) ? cur_sync[31:24] : 8'($urandom_range(0, 255));
    if (b == cur_sync[31 - 8 * k -: 8]) b = ~b;
    send_byte(b);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] sync, input logic [15:0] max_bytes);
    wait_drained();
    write_reg(REG_SYNC_WORD, sync);
    write_reg(REG_MAX_PAYLOAD, {16'd0, max_bytes});
    cur_sync = sync;
    settings_used++;
  endtask

  task automatic run_phase(input logic [31:0] sync, input logic [15:0] max_bytes);
    int          start;
    int          pick;
    logic [31:0] header;
    configure(sync, max_bytes);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        header = $urandom();
        header[15:0] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 40))
                                                   : 16'($urandom_range(0, 12));
        send_frame(header);
      end else if (pick == 7) begin
        send_broken();
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(noise_byte());
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    result_t got;
    int      stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.kind         = out_kind_e'(out_kind_o);
      got.data         = out_byte_o;
      got.frame_length = frame_length_o;
      got.process_flag = process_flag_o;
      got.payload_flag = payload_flag_o;
      got.last         = last_o;
      tracker.check_result(got);
    end
  end

  initial begin
    in_valid_i    <= 1'b0;
    stream_byte_i <= 8'd0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= 32'd0;
    rst_ni        <= 1'b0;
    cur_sync = SYNC_WORD_RST;
    quiet = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: all-zero sync word, empty frame with both flags set.
    send_frame(32'hC000_0000);

    configure(32'hA5C3_5A3C, 16'd2);
    // A mismatching byte equal to the first sync byte is not rechecked.
    send_word(32'hA5C3_A5C3);
    send_byte(8'h5A);
    send_byte(8'h3C);
    // Length above the delivery limit: two bytes delivered, one dropped.
    send_frame(32'h7FFF_0003);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: run_phase($urandom(), 16'hFFFF);
        1: run_phase(32'hFFFF_FFFF, 16'd0);
        2: run_phase(32'h0000_0000, 16'd1);
        3: run_phase($urandom(), 16'($urandom_range(1, 8)));
        4: run_phase(32'h5A5A_5A5A, 16'd3);
        5: run_phase($urandom(), 16'($urandom_range(0, 65535)));
        6: run_phase($urandom(), 16'($urandom_range(4, 16)));
        default: run_phase($urandom(), 16'd2);
      endcase
    end

    // Largest length with every header bit set; the stream ends inside the frame.
    configure($urandom(), 16'd3);
    send_word(cur_sync);
    send_word(32'hFFFF_FFFF);
    repeat (6) send_byte(8'($urandom_range(0, 255)));

    wait_drained();
    $display("Run covered %0d stream bytes under %0d register settings.",
             items_sent, settings_used + 1);
    $display("Matched %0d header and %0d payload results, %0d mismatches.",
             tracker.headers, tracker.payloads, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
